// File: hdl/cstsc_pkg.sv
// Package for the comparator threshold calibrator: phase and status codes,
// register indexes, reset values and the configuration and control structs.
// Depends on nothing; every other file in hdl/ but cstsc_outbuf uses it by scoped names.
package cstsc_pkg;

   // default parameter values
   localparam int TICK_COUNT_BITS_DEF = 12;
   localparam int DUTY_BITS_DEF       = 8;

   // round phase
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_SETTLE  = 2'd1;
   localparam logic [1:0] PH_MEASURE = 2'd2;

   // reported status
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_OK   = 2'd2;
   localparam logic [1:0] ST_FAIL = 2'd3;

   // input commands
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   // register port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SETTLE_TICKS  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_TICKS  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANGE_LIMIT  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BALANCE_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STALL_LIMIT   = 3'd4;

   // register reset values
   localparam logic [11:0] SETTLE_TICKS_RST  = 12'd150;
   localparam logic [11:0] WINDOW_TICKS_RST  = 12'd1500;
   localparam logic [7:0]  CHANGE_LIMIT_RST  = 8'd5;
   localparam logic [11:0] BALANCE_LIMIT_RST = 12'd5;
   localparam logic [3:0]  STALL_LIMIT_RST   = 4'd3;

   // counter limits
   localparam logic signed [12:0] BAL_MAX   = 13'sh0FFF;
   localparam logic signed [12:0] BAL_MIN   = 13'sh1000;
   localparam logic [11:0]        CHG_MAX   = 12'hFFF;
   localparam logic [3:0]         STALL_MAX = 4'hF;

   typedef struct packed {
      logic [11:0] settle_ticks;
      logic [11:0] window_ticks;
      logic [7:0]  change_limit;
      logic [11:0] balance_limit;
      logic [3:0]  stall_limit;
   } cstsc_cfg_type;

   typedef struct packed {
      logic [1:0]         phase;
      logic signed [12:0] balance;
      logic [11:0]        change_count;
      logic               last_pin;
      logic [3:0]         stall_count;
      logic [1:0]         result_status;
   } cstsc_ctl_type;

endpackage

// File: hdl/cstsc_step.sv
// Next-state logic of the calibrator: one item applied to the current state.
// Purely combinational; uses cstsc_pkg for codes, limits and structs.
module cstsc_step #(
   parameter int TICK_COUNT_BITS = cstsc_pkg::TICK_COUNT_BITS_DEF,
   parameter int DUTY_BITS       = cstsc_pkg::DUTY_BITS_DEF
) (
   input  cstsc_pkg::cstsc_cfg_type     cfg,
   input  logic                         command,
   input  logic                         pin_level,
   input  cstsc_pkg::cstsc_ctl_type     ctl_ff,
   input  logic [TICK_COUNT_BITS-1:0]   tick_ff,
   input  logic [DUTY_BITS-1:0]         duty_ff,
   input  logic [DUTY_BITS-2:0]         step_ff,
   input  logic [DUTY_BITS-1:0]         prev_ff,
   output cstsc_pkg::cstsc_ctl_type     ctl_in,
   output logic [TICK_COUNT_BITS-1:0]   tick_in,
   output logic [DUTY_BITS-1:0]         duty_in,
   output logic [DUTY_BITS-2:0]         step_in,
   output logic [DUTY_BITS-1:0]         prev_in,
   output logic                         done
);

   localparam int CW = (TICK_COUNT_BITS > 12) ? TICK_COUNT_BITS : 12;

   logic [TICK_COUNT_BITS-1:0] tick_inc;
   logic [CW-1:0]              tick_cmp;
   logic [CW-1:0]              settle_cmp;
   logic [CW-1:0]              win_cmp;
   logic [11:0]                win;
   logic signed [12:0]         bal_upd;
   logic [11:0]                chg_upd;
   logic signed [13:0]         bal_wide;
   logic signed [13:0]         lim_wide;
   logic [DUTY_BITS-1:0]       step_ext;
   logic [DUTY_BITS-1:0]       duty_mv;
   logic [DUTY_BITS-2:0]       step_mv;
   logic [1:0]                 first_phase;

   assign tick_inc   = tick_ff + TICK_COUNT_BITS'(1);
   assign tick_cmp   = CW'(tick_inc);
   assign settle_cmp = CW'(cfg.settle_ticks);
   assign win        = (cfg.window_ticks == 12'd0) ? 12'd1 : cfg.window_ticks;
   assign win_cmp    = CW'(win);

   // saturating balance and transition count
   always_comb begin
      if (pin_level) begin
         bal_upd = ($signed(ctl_ff.balance) == cstsc_pkg::BAL_MAX) ?
                   $signed(ctl_ff.balance) : $signed(ctl_ff.balance) + 13'sd1;
      end else begin
         bal_upd = ($signed(ctl_ff.balance) == cstsc_pkg::BAL_MIN) ?
                   $signed(ctl_ff.balance) : $signed(ctl_ff.balance) - 13'sd1;
      end
   end

   assign chg_upd = ((pin_level != ctl_ff.last_pin) &&
                     (ctl_ff.change_count != cstsc_pkg::CHG_MAX)) ?
                    ctl_ff.change_count + 12'd1 : ctl_ff.change_count;

   assign bal_wide    = {bal_upd[12], bal_upd};
   assign lim_wide    = $signed({2'b00, cfg.balance_limit});
   assign step_ext    = {1'b0, step_ff};
   assign first_phase = (cfg.settle_ticks == 12'd0) ? cstsc_pkg::PH_MEASURE
                                                    : cstsc_pkg::PH_SETTLE;

   // successive approximation move
   always_comb begin
      duty_mv = duty_ff;
      step_mv = step_ff;
      if (bal_wide >= lim_wide) begin
         duty_mv = duty_ff + step_ext;
         step_mv = step_ff >> 1;
      end else if (bal_wide <= -lim_wide) begin
         duty_mv = duty_ff - step_ext;
         step_mv = step_ff >> 1;
      end
   end

   always_comb begin
      ctl_in  = ctl_ff;
      tick_in = tick_ff;
      duty_in = duty_ff;
      step_in = step_ff;
      prev_in = prev_ff;
      done    = 1'b0;
      if (command == cstsc_pkg::CMD_START) begin
         duty_in                = DUTY_BITS'(1) << (DUTY_BITS - 1);
         step_in                = (DUTY_BITS - 1)'(1) << (DUTY_BITS - 2);
         ctl_in.stall_count     = '0;
         ctl_in.last_pin        = pin_level;
         ctl_in.result_status   = cstsc_pkg::ST_BUSY;
         tick_in                = '0;
         ctl_in.balance         = '0;
         ctl_in.change_count    = '0;
         ctl_in.phase           = first_phase;
      end else begin
         case (ctl_ff.phase)
            cstsc_pkg::PH_SETTLE: begin
               tick_in = tick_inc;
               if (tick_cmp >= settle_cmp) begin
                  tick_in      = '0;
                  ctl_in.phase = cstsc_pkg::PH_MEASURE;
               end
            end
            cstsc_pkg::PH_MEASURE: begin
               ctl_in.balance      = bal_upd;
               ctl_in.change_count = chg_upd;
               ctl_in.last_pin     = pin_level;
               tick_in             = tick_inc;
               if (tick_cmp >= win_cmp) begin
                  if (chg_upd > {4'b0000, cfg.change_limit}) begin
                     ctl_in.result_status = cstsc_pkg::ST_OK;
                     ctl_in.phase         = cstsc_pkg::PH_IDLE;
                     done                 = 1'b1;
                  end else begin
                     duty_in = duty_mv;
                     step_in = step_mv;
                     if (ctl_ff.stall_count >= cfg.stall_limit) begin
                        ctl_in.result_status = cstsc_pkg::ST_FAIL;
                        ctl_in.phase         = cstsc_pkg::PH_IDLE;
                        done                 = 1'b1;
                     end else begin
                        if ((prev_ff == duty_mv) &&
                            (ctl_ff.stall_count != cstsc_pkg::STALL_MAX)) begin
                           ctl_in.stall_count = ctl_ff.stall_count + 4'd1;
                        end
                        prev_in             = duty_mv;
                        tick_in             = '0;
                        ctl_in.balance      = '0;
                        ctl_in.change_count = '0;
                        ctl_in.phase        = first_phase;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// File: hdl/cstsc_outbuf.sv
// Two-entry result buffer: output register plus skid register.
// Standalone; no package items used.
module cstsc_outbuf #(
   parameter int WIDTH = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             out_valid,
   input  logic             out_stall,
   output logic [WIDTH-1:0] out_data,
   output logic             full
);

   logic             out_valid_ff, out_valid_in;
   logic [WIDTH-1:0] out_data_ff, out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [WIDTH-1:0] skid_data_ff, skid_data_in;
   logic             take;

   assign take = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // drain skid into output register
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign full      = skid_valid_ff;

endmodule

// File: hdl/comparator_threshold_sar_calibrator_top.sv
// Top level of the comparator threshold calibrator: registers, state, result buffer.
// Depends on cstsc_pkg, cstsc_step and cstsc_outbuf.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------
//   req     | in        | req_valid/req_stall | req_command, req_pin_level
//   rsp     | out       | rsp_valid/rsp_stall | rsp_duty_cycle, rsp_status, rsp_done_res
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One beat in per cycle while req_stall is low; its result beat is on rsp the cycle after it is taken,
// or later when an earlier result beat is still held by rsp_stall.
// The state update for a beat is a single pass through cstsc_step at the accepting edge.
// A two-entry result buffer decouples the sides: req stalls only when both entries hold.
// Reset is synchronous, active high; it loads register defaults and clears all state but the buffer data.
// csr is always ready; write registers only while no beat is outstanding.
module comparator_threshold_sar_calibrator_top #(
   parameter int TICK_COUNT_BITS = cstsc_pkg::TICK_COUNT_BITS_DEF,
   parameter int DUTY_BITS       = cstsc_pkg::DUTY_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request beats
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic                                 req_pin_level,
   // result beats
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [DUTY_BITS-1:0]                 rsp_duty_cycle,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_done_res,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cstsc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cstsc_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int RSP_BITS = DUTY_BITS + 3;

   cstsc_pkg::cstsc_cfg_type   cfg_ff, cfg_in;
   cstsc_pkg::cstsc_ctl_type   ctl_ff, ctl_in;
   logic [TICK_COUNT_BITS-1:0] tick_ff, tick_in;
   logic [DUTY_BITS-1:0]       duty_ff, duty_in;
   logic [DUTY_BITS-2:0]       step_ff, step_in;
   logic [DUTY_BITS-1:0]       prev_ff, prev_in;
   logic                       done;
   logic                       accept;
   logic                       buf_full;
   logic [RSP_BITS-1:0]        rsp_data;

   assign accept    = req_valid && !req_stall;
   assign req_stall = buf_full;
   assign csr_ready = 1'b1;

   // register file: decode index, drop writes beyond the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            cstsc_pkg::CSR_SETTLE_TICKS:  cfg_in.settle_ticks  = csr_data;
            cstsc_pkg::CSR_WINDOW_TICKS:  cfg_in.window_ticks  = csr_data;
            cstsc_pkg::CSR_CHANGE_LIMIT:  cfg_in.change_limit  = csr_data[7:0];
            cstsc_pkg::CSR_BALANCE_LIMIT: cfg_in.balance_limit = csr_data;
            cstsc_pkg::CSR_STALL_LIMIT:   cfg_in.stall_limit   = csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   cstsc_step #(
      .TICK_COUNT_BITS (TICK_COUNT_BITS),
      .DUTY_BITS       (DUTY_BITS)
   ) u_step (
      .cfg       (cfg_ff),
      .command   (req_command),
      .pin_level (req_pin_level),
      .ctl_ff    (ctl_ff),
      .tick_ff   (tick_ff),
      .duty_ff   (duty_ff),
      .step_ff   (step_ff),
      .prev_ff   (prev_ff),
      .ctl_in    (ctl_in),
      .tick_in   (tick_in),
      .duty_in   (duty_in),
      .step_in   (step_in),
      .prev_in   (prev_in),
      .done      (done)
   );

   // calibration state advances only on an accepted request beat
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ticks  <= cstsc_pkg::SETTLE_TICKS_RST;
         cfg_ff.window_ticks  <= cstsc_pkg::WINDOW_TICKS_RST;
         cfg_ff.change_limit  <= cstsc_pkg::CHANGE_LIMIT_RST;
         cfg_ff.balance_limit <= cstsc_pkg::BALANCE_LIMIT_RST;
         cfg_ff.stall_limit   <= cstsc_pkg::STALL_LIMIT_RST;
         ctl_ff.phase         <= cstsc_pkg::PH_IDLE;
         ctl_ff.balance       <= '0;
         ctl_ff.change_count  <= '0;
         ctl_ff.last_pin      <= 1'b0;
         ctl_ff.stall_count   <= '0;
         ctl_ff.result_status <= cstsc_pkg::ST_IDLE;
         tick_ff              <= '0;
         duty_ff              <= '0;
         step_ff              <= '0;
         prev_ff              <= '0;
      end else begin
         cfg_ff <= cfg_in;
         if (accept) begin
            ctl_ff  <= ctl_in;
            tick_ff <= tick_in;
            duty_ff <= duty_in;
            step_ff <= step_in;
            prev_ff <= prev_in;
         end
      end
   end

   cstsc_outbuf #(
      .WIDTH (RSP_BITS)
   ) u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data ({duty_in, ctl_in.result_status, done}),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data),
      .full      (buf_full)
   );

   assign rsp_duty_cycle = rsp_data[RSP_BITS-1:3];
   assign rsp_status     = rsp_data[2:1];
   assign rsp_done_res   = rsp_data[0];

`ifndef SYNTHESIS
   // a busy calibration always has a live round, and an idle phase never reports busy
   a_busy_phase: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.result_status == cstsc_pkg::ST_BUSY) == (ctl_ff.phase != cstsc_pkg::PH_IDLE))
      else $error("status and phase disagree");

   // a finishing beat reports success or failure
   a_done_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |->
         (rsp_status == cstsc_pkg::ST_OK || rsp_status == cstsc_pkg::ST_FAIL))
      else $error("done without final status");

   // duty code moves only on an accepted request beat
   a_duty_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(duty_ff))
      else $error("duty changed without a beat");

   // skid entry is only ever occupied behind a full output register
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      buf_full |-> rsp_valid)
      else $error("skid holds data with empty output register");
`endif

endmodule
